### rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Opcodes, status codes and the front-to-back work descriptor.
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int WIDTH_DEF = 32;
    localparam int XW        = 64;  // double-width product lane

    localparam logic [2:0] OP_NORM = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_EQ   = 3'd5;
    localparam logic [2:0] OP_LT   = 3'd6;
    localparam logic [2:0] OP_NONE = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // Classified request passed from front to back.
    typedef struct packed {
        logic [2:0]    op;
        logic          done;   // result already decided in the front
        logic [1:0]    st;
        logic          a_neg;
        logic          b_neg;
        logic [31:0]   a_n;
        logic [31:0]   a_d;
        logic [31:0]   b_n;
        logic [31:0]   b_d;
    } t_work;
endpackage

### rtl/core/rau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if: request and result channels
// Valid/ready handshake with the payload fields.
// ----------------------------------------------------------------------------
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [30:0] b_den;
    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        cmp_flag;
    logic [1:0]  status;
    modport source (output valid, res_num, res_den, cmp_flag, status, input ready);
    modport sink   (input valid, res_num, res_den, cmp_flag, status, output ready);
endinterface

### rtl/core/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact signed-fraction arithmetic
//
// i_req carries an opcode and two fractions; o_res returns one reduced
// fraction, a compare flag and a status per request (valid/ready each).
// The front folds signs and flags zero denominators in the accept cycle
// and queues the request (two entries), so intake runs ahead of execution.
// The back forms cross products on one shared 32x32 multiplier, runs
// Euclid's loop with a bit-serial remainder unit (a data-dependent number
// of remainder steps), then divides numerator and denominator by the gcd.
// Error and compare requests skip Euclid's loop and the divides. The
// result register holds until o_res.ready; while it waits the queue keeps
// taking requests until full. Reset empties the queue and returns the back
// to idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_req,
    rau_out_if.source o_res
);
    rau_pkg::t_work w_work;
    logic           w_valid, w_ready;

    rau_front #(.WIDTH(WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_req,
        .o_work(w_work), .o_work_valid(w_valid), .i_work_ready(w_ready)
    );

    rau_back #(.WIDTH(WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_work(w_work), .i_work_valid(w_valid), .o_work_ready(w_ready), .o_res
    );
endmodule

### rtl/core/rau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_front: request intake and classification
// Folds signs, flags zero denominators, pushes a work word into a queue.
// ----------------------------------------------------------------------------
module rau_front #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rau_in_if.sink         i_req,
    output rau_pkg::t_work o_work,
    output logic           o_work_valid,
    input  logic           i_work_ready
);
    localparam int DEPTH = 2;

    rau_pkg::t_work r_q [DEPTH];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    rau_pkg::t_work n_w;

    logic signed [WIDTH-1:0] an, ad, bn;
    logic [WIDTH-2:0]        bd;
    logic [WIDTH-1:0]        an_m, ad_m, bn_m;

    always_comb begin
        an   = i_req.a_num[WIDTH-1:0];
        ad   = i_req.a_den[WIDTH-1:0];
        bn   = i_req.b_num[WIDTH-1:0];
        bd   = i_req.b_den[WIDTH-2:0];
        an_m = an[WIDTH-1] ? (~an + 1'b1) : an;
        ad_m = ad[WIDTH-1] ? (~ad + 1'b1) : ad;
        bn_m = bn[WIDTH-1] ? (~bn + 1'b1) : bn;
        n_w       = '0;
        n_w.op    = i_req.req_type;
        n_w.a_n   = 32'(an_m);
        n_w.a_d   = 32'(ad_m);
        n_w.b_n   = 32'(bn_m);
        n_w.b_d   = 32'(bd);
        n_w.a_neg = (an != 0) && (an[WIDTH-1] != ad[WIDTH-1]);
        n_w.b_neg = (bn != 0) && bn[WIDTH-1];
        n_w.st    = rau_pkg::ST_OK;
        if (i_req.req_type == rau_pkg::OP_NONE) begin
            n_w.done = 1'b1;
        end else if (ad == 0 || (i_req.req_type != rau_pkg::OP_NORM && bd == 0) ||
                     (i_req.req_type == rau_pkg::OP_DIV && bn == 0)) begin
            n_w.done = 1'b1;
            n_w.st   = rau_pkg::ST_ZERO;
        end
    end

    assign i_req.ready  = (r_cnt != 2'(DEPTH));
    assign o_work_valid = (r_cnt != 0);
    assign o_work       = r_q[r_rp];

    wire push = i_req.valid && i_req.ready;
    wire pop  = o_work_valid && i_work_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= n_w;
                r_wp      <= ~r_wp;
            end
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

### rtl/core/rau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_back: execution sequencer
// Cross products via one 32x32 multiplier, then bit-serial restoring
// remainder steps for Euclid's loop, then two serial divides to reduce.
// ----------------------------------------------------------------------------
module rau_back #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rau_pkg::t_work i_work,
    input  logic           i_work_valid,
    output logic           o_work_ready,
    rau_out_if.source      o_res
);
    localparam int XW = rau_pkg::XW;
    localparam int CW = $clog2(XW + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_COMB = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_DIVN = 4'd6;
    localparam logic [3:0] S_DIVD = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]    r_st;
    rau_pkg::t_work r_w;
    logic [XW-1:0] r_t1, r_t2, r_dd;     // products
    logic [XW-1:0] r_n, r_d;
    logic          r_neg;
    logic [XW-1:0] r_x, r_y;             // gcd operands
    logic [XW-1:0] r_q, r_rem;           // serial divider
    logic [CW-1:0] r_cnt;
    logic          r_first;
    logic [XW-1:0] r_g;
    logic [XW-1:0] r_rn;

    logic [31:0] r_res_num;
    logic [30:0] r_res_den;
    logic        r_cmp;
    logic [1:0]  r_sts;

    // single shared multiplier
    logic [31:0]   m_a, m_b;
    logic [XW-1:0] m_p;
    assign m_p = XW'(m_a) * XW'(m_b);

    always_comb begin
        m_a = r_w.a_n; m_b = r_w.b_d;
        unique case (r_st)
            S_M0: begin
                m_a = r_w.a_n;
                m_b = (r_w.op == rau_pkg::OP_MUL) ? r_w.b_n : r_w.b_d;
            end
            S_M1: begin
                m_a = r_w.a_d;
                m_b = (r_w.op == rau_pkg::OP_DIV) ? r_w.b_n : r_w.b_d;
            end
            S_M2: begin
                m_a = r_w.b_n; m_b = r_w.a_d;
            end
            default: ;
        endcase
    end

    // one restoring divide step on r_rem/r_q with divisor div_by
    logic [XW-1:0] div_by;
    logic [XW:0]   trial;
    logic [XW-1:0] sh_rem;
    always_comb begin
        unique case (r_st)
            S_GCD:   div_by = r_y;
            default: div_by = r_g;
        endcase
        sh_rem = {r_rem[XW-2:0], r_q[XW-1]};
        trial  = {r_rem[XW-1], sh_rem} - {1'b0, div_by};
    end
    wire          fits    = !trial[XW];
    wire [XW-1:0] rem_nxt = fits ? trial[XW-1:0] : sh_rem;
    wire [XW-1:0] q_nxt   = {r_q[XW-2:0], fits};

    localparam logic [XW-1:0] LIM = XW'((64'd1 << (WIDTH - 1)) - 1);

    assign o_work_ready = (r_st == S_IDLE);
    assign o_res.valid    = (r_st == S_OUT);
    assign o_res.res_num  = r_res_num;
    assign o_res.res_den  = r_res_den;
    assign o_res.cmp_flag = r_cmp;
    assign o_res.status   = r_sts;

    logic signed [XW:0] sx, sy;
    always_comb begin
        sx = r_w.a_neg ? -$signed({1'b0, r_t1}) : $signed({1'b0, r_t1});
        sy = r_w.b_neg ? -$signed({1'b0, r_t2}) : $signed({1'b0, r_t2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            unique case (r_st)
                S_IDLE: if (i_work_valid) begin
                    r_w <= i_work;
                    r_res_num <= '0; r_res_den <= 31'd1; r_cmp <= 1'b0;
                    r_sts <= i_work.st;
                    if (i_work.done) r_st <= S_OUT;
                    else if (i_work.op == rau_pkg::OP_NORM) begin
                        r_n <= XW'(i_work.a_n); r_d <= XW'(i_work.a_d);
                        r_neg <= i_work.a_neg;
                        r_st <= S_COMB;
                    end else r_st <= S_M0;
                end
                S_M0: begin r_t1 <= m_p; r_st <= S_M1; end
                S_M1: begin r_dd <= m_p; r_st <= S_M2; end
                S_M2: begin r_t2 <= m_p; r_st <= S_COMB; end
                S_COMB: begin
                    // assemble n/d and sign, or finish a comparison
                    if (r_w.op == rau_pkg::OP_EQ || r_w.op == rau_pkg::OP_LT) begin
                        r_cmp <= (r_w.op == rau_pkg::OP_EQ) ? (sx == sy) : (sx < sy);
                        r_st  <= S_OUT;
                    end else begin
                        if (r_w.op == rau_pkg::OP_ADD || r_w.op == rau_pkg::OP_SUB) begin
                            logic s2;
                            s2 = (r_w.op == rau_pkg::OP_SUB) ? !r_w.b_neg : r_w.b_neg;
                            if (r_t2 == 0) s2 = r_w.a_neg;
                            if (s2 == r_w.a_neg) begin
                                r_n <= r_t1 + r_t2; r_neg <= r_w.a_neg;
                                r_x <= r_t1 + r_t2;
                            end else if (r_t1 >= r_t2) begin
                                r_n <= r_t1 - r_t2; r_neg <= r_w.a_neg;
                                r_x <= r_t1 - r_t2;
                            end else begin
                                r_n <= r_t2 - r_t1; r_neg <= s2;
                                r_x <= r_t2 - r_t1;
                            end
                            r_d <= r_dd; r_y <= r_dd;
                        end else if (r_w.op == rau_pkg::OP_MUL ||
                                     r_w.op == rau_pkg::OP_DIV) begin
                            r_n <= r_t1; r_d <= r_dd; r_x <= r_t1; r_y <= r_dd;
                            r_neg <= r_w.a_neg != r_w.b_neg;
                        end else begin
                            r_x <= r_n; r_y <= r_d;
                        end
                        r_first <= 1'b1;
                        r_st <= S_GCD;
                    end
                end
                S_GCD: begin
                    // x % y one bit per cycle; swap when a remainder is done
                    if (r_first) begin
                        if (r_y == 0) begin
                            r_g <= r_x; r_rem <= '0; r_q <= r_n;
                            r_cnt <= '0; r_st <= S_DIVN;
                        end else begin
                            r_rem <= '0; r_q <= r_x; r_cnt <= '0; r_first <= 1'b0;
                        end
                    end else begin
                        r_rem <= rem_nxt; r_q <= q_nxt;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CW'(XW - 1)) begin
                            r_x <= r_y; r_y <= rem_nxt; r_first <= 1'b1;
                        end
                    end
                end
                S_DIVN: begin
                    r_rem <= rem_nxt; r_q <= q_nxt; r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(XW - 1)) begin
                        r_rn <= q_nxt; r_rem <= '0; r_q <= r_d; r_cnt <= '0;
                        r_st <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    r_rem <= rem_nxt; r_q <= q_nxt; r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(XW - 1)) begin
                        r_d <= q_nxt; r_st <= S_FIN;
                    end
                end
                S_FIN: begin
                    logic ng;
                    logic ov;
                    ng = r_neg && (r_rn != 0);
                    ov = (r_d > LIM) || (r_rn > (ng ? LIM + 1'b1 : LIM));
                    if (ov) r_sts <= rau_pkg::ST_OVF;
                    else begin
                        r_res_num <= 32'(ng ? (~r_rn + 1'b1) : r_rn);
                        r_res_den <= 31'(r_d);
                    end
                    r_st <= S_OUT;
                end
                S_OUT: if (o_res.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

### tb/sv/rational_arithmetic_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test: self-checking bench for the fraction unit
// Directed and random requests over every opcode with random idle and stall
// on both channels. An in-bench model predicts each reduced result, and a
// checker compares every returned result field by field in order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] MINUS1  = 32'hFFFF_FFFF;

    typedef struct {
        logic [31:0] num;
        logic [30:0] den;
        logic        cmp;
        logic [1:0]  st;
    } t_fraction_result;

    logic i_clk;
    logic i_rst_n;

    rau_in_if  req_if ();
    rau_out_if res_if ();

    rational_arithmetic_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_fraction_result pending_results[$];
    int     error_count;
    longint cycle_count;
    int     gap_pct;       // sender idle chance, percent
    int     stall_pct;     // receiver stall chance, percent
    int     hold_left;     // forced receiver hold-off, in cycles

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_fraction_result fixed_result(logic cmp, logic [1:0] st);
        t_fraction_result r;
        r.num = '0;
        r.den = 31'd1;
        r.cmp = cmp;
        r.st  = st;
        return r;
    endfunction

    // Reduce by the gcd and range-check; d is never zero here.
    function automatic t_fraction_result reduce_fraction(bit neg, longint unsigned n,
                                                         longint unsigned d);
        longint unsigned g, lim;
        t_fraction_result r;
        g   = euclid_gcd(n, d);
        lim = 64'h7FFF_FFFF;
        n   = n / g;
        d   = d / g;
        if (n == 0)
            neg = 1'b0;
        if (d > lim || n > (neg ? lim + 1 : lim))
            return fixed_result(1'b0, rau_pkg::ST_OVF);
        r.num = neg ? 32'(longint'(0) - n) : n[31:0];
        r.den = d[30:0];
        r.cmp = 1'b0;
        r.st  = rau_pkg::ST_OK;
        return r;
    endfunction

    function automatic t_fraction_result predict_fraction(logic [2:0] op, logic [31:0] an,
                                                          logic [31:0] ad, logic [31:0] bn,
                                                          logic [30:0] bd);
        longint          an_s, ad_s, bn_s, bd_s, x, y;
        longint unsigned a_n, a_d, b_n, b_d, t1, t2, n;
        bit              a_neg, b_neg, s1, s2, neg, c;
        an_s  = longint'($signed(an));
        ad_s  = longint'($signed(ad));
        bn_s  = longint'($signed(bn));
        bd_s  = longint'({1'b0, bd});
        a_n   = magnitude(an_s);
        a_d   = magnitude(ad_s);
        b_n   = magnitude(bn_s);
        b_d   = bd_s;
        // sign of the denominator folds into the numerator
        a_neg = (an_s != 0) && ((an_s < 0) != (ad_s < 0));
        b_neg = (bn_s < 0);
        if (op == rau_pkg::OP_NONE)
            return fixed_result(1'b0, rau_pkg::ST_OK);
        if (a_d == 0 || (op != rau_pkg::OP_NORM && b_d == 0))
            return fixed_result(1'b0, rau_pkg::ST_ZERO);
        case (op)
            rau_pkg::OP_NORM: begin
                return reduce_fraction(a_neg, a_n, a_d);
            end
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                t1 = a_n * b_d;
                t2 = b_n * a_d;
                s1 = a_neg;
                s2 = (op == rau_pkg::OP_SUB) ? !b_neg : b_neg;
                if (t2 == 0)
                    s2 = s1;
                if (s1 == s2) begin
                    n = t1 + t2;
                    neg = s1;
                end else if (t1 >= t2) begin
                    n = t1 - t2;
                    neg = s1;
                end else begin
                    n = t2 - t1;
                    neg = s2;
                end
                return reduce_fraction(neg, n, a_d * b_d);
            end
            rau_pkg::OP_MUL: begin
                return reduce_fraction(a_neg != b_neg, a_n * b_n, a_d * b_d);
            end
            rau_pkg::OP_DIV: begin
                if (b_n == 0)
                    return fixed_result(1'b0, rau_pkg::ST_ZERO);
                return reduce_fraction(a_neg != b_neg, a_n * b_d, a_d * b_n);
            end
            default: begin
                x = a_n * b_d;
                y = b_n * a_d;
                if (a_neg)
                    x = -x;
                if (b_neg)
                    y = -y;
                c = (op == rau_pkg::OP_EQ) ? (x == y) : (x < y);
                return fixed_result(c, rau_pkg::ST_OK);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    task automatic compare_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, expected, actual);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_fraction_result exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h/%h", $time,
                         res_if.res_num, res_if.res_den);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                compare_field("res_num", exp_res.num, res_if.res_num);
                compare_field("res_den", 32'(exp_res.den), 32'(res_if.res_den));
                compare_field("cmp_flag", 32'(exp_res.cmp), 32'(res_if.cmp_flag));
                compare_field("status", 32'(exp_res.st), 32'(res_if.status));
            end
        end
    end

    // Receiver: forced hold-off first, else random stall.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("rational_arithmetic_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender: called at a falling edge, returns at a falling edge.
    // valid stays high between back-to-back requests.
    // ------------------------------------------------------------------
    task automatic send_request(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [30:0] bd);
        int gap;
        gap = 0;
        if ($urandom_range(99) < gap_pct)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= op;
        req_if.a_num    <= an;
        req_if.a_den    <= ad;
        req_if.b_num    <= bn;
        req_if.b_den    <= bd;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(predict_fraction(op, an, ad, bn, bd));
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Random operands: mostly small so the gcd loop stays short
    // ------------------------------------------------------------------
    function automatic logic [31:0] random_operand();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return 32'($signed($urandom_range(2000)) - 1000);
            6, 7:             return 32'($signed($urandom_range(131071)) - 65536);
            8:                return $urandom;
            default: begin
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return 32'd1;
                    2:       return MINUS1;
                    3:       return INT_MIN;
                    default: return INT_MAX;
                endcase
            end
        endcase
    endfunction

    function automatic logic [30:0] random_denominator();
        case ($urandom_range(19))
            0:       return '0;                              // zero denominator
            1, 2:    return 31'($urandom);
            3:       return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(1, 1000));
        endcase
    endfunction

    function automatic logic [2:0] random_opcode();
        if ($urandom_range(99) < 2)
            return rau_pkg::OP_NONE;
        return 3'($urandom_range(0, 6));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        gap_pct   = 0;
        stall_pct = 0;
        send_request(rau_pkg::OP_NORM, 32'd6, -32'sd4, '0, 31'd1);     // sign moves up
        send_request(rau_pkg::OP_NORM, INT_MIN, MINUS1, '0, 31'd1);    // 2^31 overflows
        send_request(rau_pkg::OP_NORM, INT_MIN, INT_MIN, '0, 31'd1);
        send_request(rau_pkg::OP_NORM, '0, -32'sd5, '0, 31'd0);        // zero stays positive
        send_request(rau_pkg::OP_NORM, 32'd7, '0, '0, 31'd1);          // zero denominator
        send_request(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 31'd3);
        send_request(rau_pkg::OP_ADD, INT_MAX, 32'd1, 32'd1, 31'd1);   // overflow
        send_request(rau_pkg::OP_ADD, 32'd1, INT_MAX, 32'd1,
                     31'h7FFF_FFFE);                                   // denominator too big
        send_request(rau_pkg::OP_ADD, MINUS1, MINUS1, MINUS1, 31'h7FFF_FFFF);
        send_request(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 31'd2);     // zero result
        send_request(rau_pkg::OP_SUB, 32'd3, -32'sd4, INT_MIN, 31'd1); // non-normal a
        send_request(rau_pkg::OP_SUB, INT_MIN, 32'd1, INT_MAX, 31'd1);
        send_request(rau_pkg::OP_MUL, INT_MIN, 32'd1, MINUS1, 31'd1);  // overflow
        send_request(rau_pkg::OP_MUL, 32'd7, 32'd3, 32'd3, 31'd7);
        send_request(rau_pkg::OP_MUL, INT_MIN, 32'd1, INT_MIN, 31'h7FFF_FFFF);
        send_request(rau_pkg::OP_DIV, 32'd1, 32'd2, '0, 31'd1);        // divide by zero
        send_request(rau_pkg::OP_DIV, -32'sd3, 32'd4, 32'd5, 31'd6);
        send_request(rau_pkg::OP_DIV, 32'd1, 32'd2, 32'd1, 31'd0);     // b_den zero
        send_request(rau_pkg::OP_EQ, 32'd1, 32'd2, 32'd2, 31'd4);
        send_request(rau_pkg::OP_EQ, 32'd1, 32'd3, 32'd1, 31'd2);
        send_request(rau_pkg::OP_LT, MINUS1, 32'd2, 32'd1, 31'd3);
        send_request(rau_pkg::OP_LT, 32'd1, 32'd2, 32'd1, 31'd3);
        send_request(rau_pkg::OP_LT, INT_MAX, 32'd1, INT_MIN, 31'h7FFF_FFFF);
        send_request(rau_pkg::OP_NONE, MINUS1, '0, MINUS1, 31'h7FFF_FFFF);
        go_idle();
    endtask

    task automatic test_random(int count, int gap, int stall);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (count)
            send_request(random_opcode(), random_operand(), random_operand(),
                         random_operand(), random_denominator());
        go_idle();
    endtask

    // Receiver holds off while cheap requests keep coming, so the queue
    // fills and intake must stall.
    task automatic test_backpressure();
        gap_pct   = 0;
        stall_pct = 0;
        hold_left = 400;
        repeat (8)
            send_request($urandom_range(1) ? rau_pkg::OP_EQ : rau_pkg::OP_LT,
                         random_operand(), 32'($urandom_range(1, 50)), random_operand(),
                         31'($urandom_range(1, 50)));
        go_idle();
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        gap_pct         = 0;
        stall_pct       = 0;
        hold_left       = 0;
        req_if.valid    = 1'b0;
        req_if.req_type = rau_pkg::OP_NORM;
        req_if.a_num    = '0;
        req_if.a_den    = 32'd1;
        req_if.b_num    = '0;
        req_if.b_den    = 31'd1;
        res_if.ready    = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(350, 0, 0);
        test_backpressure();
        test_random(350, 52, 0);
        test_random(350, 0, 52);
        test_random(350, 19, 19);

        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (50) @(negedge i_clk);

        if (error_count == 0)
            $display("rational_arithmetic_unit test passed");
        else
            $display("rational_arithmetic_unit test failed");
        $finish;
    end
endmodule

### sim.f
rtl/core/rau_pkg.sv
rtl/core/rau_if.sv
rtl/core/rau_front.sv
rtl/core/rau_back.sv
rtl/core/rational_arithmetic_unit.sv
tb/sv/rational_arithmetic_unit_test.sv
